/* design/top_k_sum_count_tree_defines.svh */
// Assertion macros shared by the checker of the top-k sum tree.
`ifndef TOP_K_SUM_COUNT_TREE_DEFINES_SVH
`define TOP_K_SUM_COUNT_TREE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TKS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TKS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tksct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tksct_pkg;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned K_W     = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SUM_W   = 64;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // One tree node: entry count and sum of values
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } node_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture an input word
    logic clr_wr;     // write zero at the sweep pointer and advance
    logic chk_rd;     // read the node that gates a modify
    logic up_rd;      // read the current node on the upward walk
    logic up_wr;      // write back the updated node and step to the parent
    logic q_rd;       // read the right child, or the leaf at the bottom
    logic q_eval;     // take or descend on the right child
    logic leaf_eval;  // take the final leaf when it fits
    logic out_load;   // move the accumulator into the result register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_query;   // incoming word is a query
    logic in_mod_ok;  // incoming word is an insert or remove on a valid slot
    logic clr_last;   // sweep pointer at the last node
    logic chk_ok;     // gating node allows the modify
    logic at_root;    // current node is the root
    logic at_leaf;    // current node is a leaf
    logic k_zero;     // remaining k is zero
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/tksct_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tksct_dp #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tksct_pkg::dp_cmd_t                   cmd_i,
  output tksct_pkg::dp_sts_t                   sts_o,
  input  logic        [tksct_pkg::OP_W-1:0]    op_i,
  input  logic        [tksct_pkg::SLOT_W-1:0]  slot_i,
  input  logic signed [tksct_pkg::VALUE_W-1:0] value_i,
  input  logic        [tksct_pkg::K_W-1:0]     k_count_i,
  output logic signed [tksct_pkg::SUM_W-1:0]   top_sum_o
);
  import tksct_pkg::*;

  localparam int unsigned LVL   = $clog2(LEAVES);
  localparam int unsigned P     = 1 << LVL;
  localparam int unsigned NW    = LVL + 1;
  localparam int unsigned DEPTH = 2 * P;

  node_t              node_mem_q [DEPTH];
  node_t              rd_q;
  node_t              upd;
  node_t              wr_data;
  logic [NW-1:0]      rd_addr;
  logic [NW-1:0]      wr_addr;
  logic               rd_en;
  logic               wr_en;

  logic [NW-1:0]      clr_ptr_q;
  logic [OP_W-1:0]    op_q;
  logic [NW-1:0]      p_q;
  logic [K_W-1:0]     k_q;
  logic [SUM_W-1:0]   val_q;
  logic [SUM_W-1:0]   acc_q;
  logic [SUM_W-1:0]   top_sum_q;

  logic [NW-1:0]      leaf_addr;
  logic               in_slot_ok;
  logic               is_ins;
  logic               fits;

  // Decode the incoming word
  assign leaf_addr  = NW'(P) | NW'(slot_i);
  assign in_slot_ok = (32'(slot_i) < 32'(LEAVES));
  assign is_ins     = (op_q == OP_INSERT);
  assign fits       = (rd_q.cnt <= k_q);

  // Status toward the controller
  always_comb begin
    sts_o.in_query  = (op_i == OP_QUERY);
    sts_o.in_mod_ok = ((op_i == OP_INSERT) || (op_i == OP_REMOVE)) && in_slot_ok;
    sts_o.clr_last  = &clr_ptr_q;
    sts_o.chk_ok    = is_ins ? (rd_q.cnt != '1) : (rd_q.cnt != '0);
    sts_o.at_root   = (p_q == NW'(1));
    sts_o.at_leaf   = p_q[NW-1];
    sts_o.k_zero    = (k_q == '0);
  end

  // Select the read address
  always_comb begin
    rd_en   = cmd_i.chk_rd | cmd_i.up_rd | cmd_i.q_rd;
    rd_addr = p_q;
    priority if (cmd_i.chk_rd) begin
      rd_addr = is_ins ? NW'(1) : p_q;
    end else if (cmd_i.q_rd) begin
      rd_addr = p_q[NW-1] ? p_q : {p_q[NW-2:0], 1'b1};
    end else begin
      rd_addr = p_q;
    end
  end

  // Build the updated node and select the write
  always_comb begin
    upd.cnt = is_ins ? (rd_q.cnt + CNT_W'(1)) : (rd_q.cnt - CNT_W'(1));
    upd.sum = is_ins ? (rd_q.sum + val_q) : (rd_q.sum - val_q);
    wr_en   = cmd_i.clr_wr | cmd_i.up_wr;
    wr_addr = cmd_i.clr_wr ? clr_ptr_q : p_q;
    wr_data = cmd_i.clr_wr ? '0 : upd;
  end

  // Node memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= node_mem_q[rd_addr];
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_ptr_q <= clr_ptr_q + NW'(1);
    end
  end

  // Working registers of the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      k_q   <= k_count_i;
      val_q <= {{(SUM_W - VALUE_W){value_i[VALUE_W-1]}}, value_i};
      acc_q <= '0;
      p_q   <= (op_i == OP_QUERY) ? NW'(1) : leaf_addr;
    end
    if (cmd_i.up_wr) begin
      p_q <= p_q >> 1;
    end
    if (cmd_i.q_eval) begin
      if (fits) begin
        acc_q <= acc_q + rd_q.sum;
        k_q   <= k_q - rd_q.cnt;
        p_q   <= {p_q[NW-2:0], 1'b0};
      end else begin
        p_q   <= {p_q[NW-2:0], 1'b1};
      end
    end
    if (cmd_i.leaf_eval && fits) begin
      acc_q <= acc_q + rd_q.sum;
    end
    if (cmd_i.out_load) begin
      top_sum_q <= acc_q;
    end
  end

  assign top_sum_o = top_sum_q;

endmodule

`default_nettype wire

/* design/tksct_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tksct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  tksct_pkg::dp_sts_t sts_i,
  output tksct_pkg::dp_cmd_t cmd_o
);
  import tksct_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_CHK_RD = 10'b00_0000_0100,
    S_CHK    = 10'b00_0000_1000,
    S_UP_RD  = 10'b00_0001_0000,
    S_UP_WR  = 10'b00_0010_0000,
    S_Q_RD   = 10'b00_0100_0000,
    S_Q_EVAL = 10'b00_1000_0000,
    S_LEAF   = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence the sweep, the upward walk and the downward walk
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_query) begin
            state_d = S_Q_RD;
          end else if (sts_i.in_mod_ok) begin
            state_d = S_CHK_RD;
          end
        end
      end
      S_CHK_RD: begin
        cmd_o.chk_rd = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        state_d = sts_i.chk_ok ? S_UP_RD : S_IDLE;
      end
      S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d     = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.up_wr = 1'b1;
        state_d     = sts_i.at_root ? S_IDLE : S_UP_RD;
      end
      S_Q_RD: begin
        if (sts_i.k_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.q_rd = 1'b1;
          state_d    = sts_i.at_leaf ? S_LEAF : S_Q_EVAL;
        end
      end
      S_Q_EVAL: begin
        cmd_o.q_eval = 1'b1;
        state_d      = S_Q_RD;
      end
      S_LEAF: begin
        cmd_o.leaf_eval = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/top_k_sum_count_tree.sv */
// Insert/remove: a gate check, then an upward walk from the leaf to the root; one read and
//   one write per tree level on the single node memory port pair.
// Query: a downward walk from the root; the result is registered at its end and the next word
//   is accepted after that, sooner when k runs out, later while a result waits.
// Dropped words: bad op or slot in S_IDLE, full tree or empty slot after the gate check.
// Reset: a clearing sweep over all 2*P nodes zeroes the node memory, input stalled.
`timescale 1ns / 1ps
`default_nettype none

module top_k_sum_count_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [tksct_pkg::OP_W-1:0]    op_i,
  input  logic        [tksct_pkg::SLOT_W-1:0]  slot_i,
  input  logic signed [tksct_pkg::VALUE_W-1:0] value_i,
  input  logic        [tksct_pkg::K_W-1:0]     k_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tksct_pkg::SUM_W-1:0]   top_sum_o
);
  import tksct_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  tksct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Node memory and walk registers
  tksct_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .op_i      (op_i),
    .slot_i    (slot_i),
    .value_i   (value_i),
    .k_count_i (k_count_i),
    .top_sum_o (top_sum_o)
  );

endmodule

`default_nettype wire

/* design/tksct_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_sum_count_tree_defines.svh"

module tksct_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic        [tksct_pkg::OP_W-1:0]    op_i,
  input logic        [tksct_pkg::SLOT_W-1:0]  slot_i,
  input logic signed [tksct_pkg::VALUE_W-1:0] value_i,
  input logic        [tksct_pkg::K_W-1:0]     k_count_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [tksct_pkg::SUM_W-1:0]   top_sum_o
);
  import tksct_pkg::*;

  // A stalled result word stays offered
  `TKS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A stalled result word keeps its value
  `TKS_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(top_sum_o), "result changed while stalled")

  // A query keeps the block busy in the following cycle
  `TKS_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && op_i == OP_QUERY, in_stall_o, "query did not stall input")

  // A query cannot produce its result in the next cycle
  `TKS_ASSERT_NEXT(a_query_latency, in_valid_i && !in_stall_o && op_i == OP_QUERY && !out_valid_o, !out_valid_o, "result too early")

endmodule

bind top_k_sum_count_tree tksct_checker u_checker (.*);

`default_nettype wire
